// ===== hw/rtl/tilt_pkg.sv =====
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared types and constants for the accelerometer tilt angle core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tilt_pkg;

    localparam int ATAN_COUNT = 32;

    // round(atan(2^-i) * 2^30)
    localparam logic signed [31:0] ATAN_Q30 [0:ATAN_COUNT-1] = '{
        32'sd843314857, 32'sd497837830, 32'sd263043837, 32'sd133525159, 32'sd67021687,
        32'sd33543516, 32'sd16775851, 32'sd8388437, 32'sd4194283, 32'sd2097149,
        32'sd1048576, 32'sd524288, 32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
        32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256,
        32'sd128, 32'sd64, 32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2, 32'sd1, 32'sd0
    };

    localparam logic [1:0] FUNC_TILT_Z  = 2'd0;
    localparam logic [1:0] FUNC_ANGLE_X = 2'd1;
    localparam logic [1:0] FUNC_ANGLE_Y = 2'd2;
    localparam logic [1:0] FUNC_SCALE_X = 2'd3;

    // Per-word side data carried down the pipe.
    typedef struct packed {
        logic [1:0]         func;
        logic               neg;
        logic signed [11:0] scale;
    } meta_t;

    // Square root cell word.
    typedef struct packed {
        logic [31:0] src;
        logic [34:0] rem;
        logic [31:0] root;
        logic [16:0] plain;
        meta_t       meta;
    } sq_t;

    // CORDIC cell word.
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [31:0] z;
        logic               num_zero;
        logic               den_zero;
        meta_t              meta;
    } cord_t;

endpackage

// ===== hw/rtl/accel_tilt_angle_core.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angle_core
// Tilt angle (tenths of a degree) or scaled x acceleration from one sample.
// ----------------------------------------------------------------------------
// The core takes one word per cycle while in_stall is low and returns one
// result per word, in order, through one squaring stage, a chain of 32
// square root cells, CORDIC_STEPS CORDIC cells, one multiply stage and the
// output register. The whole chain advances together and holds only while
// a finished result waits under out_stall.
`timescale 1ns / 1ps

module accel_tilt_angle_core
    import tilt_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] result_value
);

    localparam int SQ_CELLS = 32;

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- entry stage: squares and scaling ----------------
    logic signed [15:0] sel_a, sel_b, sel_c;
    logic signed [31:0] sq_a, sq_b;
    logic signed [25:0] prod_x;
    logic signed [25:0] prod_adj;
    meta_t              meta_in;
    logic [16:0]        mag_c;

    always_comb
    begin
        case (func)
            FUNC_TILT_Z:
            begin
                sel_a = accel_x; sel_b = accel_y; sel_c = accel_z;
            end
            FUNC_ANGLE_X:
            begin
                sel_a = accel_y; sel_b = accel_z; sel_c = accel_x;
            end
            default:
            begin
                sel_a = accel_x; sel_b = accel_z; sel_c = accel_y;
            end
        endcase
        sq_a     = sel_a * sel_a;
        sq_b     = sel_b * sel_b;
        mag_c    = sel_c[15] ? (17'd0 - {sel_c[15], sel_c}) : {1'b0, sel_c};
        prod_x   = 26'(accel_x) * 26'sd980;
        // bias negatives so the shift truncates toward zero
        prod_adj = prod_x + (prod_x[25] ? 26'sd16383 : 26'sd0);
        meta_in.func  = func;
        meta_in.neg   = sel_c[15];
        meta_in.scale = 12'(prod_adj >>> 14);
    end

    sq_t  sq_d [0:SQ_CELLS];
    logic sq_v [0:SQ_CELLS];
    sq_t  sq0_reg;
    logic sq0_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq0_reg.src   <= 32'(sq_a) + 32'(sq_b);
            sq0_reg.rem   <= '0;
            sq0_reg.root  <= '0;
            sq0_reg.plain <= mag_c;
            sq0_reg.meta  <= meta_in;
        end
    end

    assign sq_d[0] = sq0_reg;
    assign sq_v[0] = sq0_v_reg;

    // radicand is sum << 32: the zero low half shifts in behind the sum
    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sqrt
        tilt_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (sq_v[i]),
            .in_d  (sq_d[i]),
            .out_v (sq_v[i+1]),
            .out_d (sq_d[i+1])
        );
    end

    // ---------------- CORDIC chain ----------------
    cord_t       cd_d [0:CORDIC_STEPS];
    logic        cd_v [0:CORDIC_STEPS];
    cord_t       cd_first;
    logic [31:0] plain_q16;
    logic [31:0] num_w, den_w;

    always_comb
    begin
        plain_q16 = {sq_d[SQ_CELLS].plain[15:0], 16'd0};
        if (sq_d[SQ_CELLS].meta.func == FUNC_TILT_Z)
        begin
            num_w = sq_d[SQ_CELLS].root;
            den_w = plain_q16;
        end
        else
        begin
            num_w = plain_q16;
            den_w = sq_d[SQ_CELLS].root;
        end
        cd_first.x        = {4'd0, den_w};
        cd_first.y        = {4'd0, num_w};
        cd_first.z        = '0;
        cd_first.num_zero = (num_w == 32'd0);
        cd_first.den_zero = (den_w == 32'd0);
        cd_first.meta     = sq_d[SQ_CELLS].meta;
    end

    assign cd_d[0] = cd_first;
    assign cd_v[0] = sq_v[SQ_CELLS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        tilt_cordic_cell #(.IDX(i)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (cd_v[i]),
            .in_d  (cd_d[i]),
            .out_v (cd_v[i+1]),
            .out_d (cd_d[i+1])
        );
    end

    // ---------------- radians to tenths ----------------
    // t = floor(z * 2250000 / (3927 * 2^30)); estimate by reciprocal, fix by one
    localparam logic [19:0] RECIP   = 20'd586707;
    localparam logic [21:0] NUMER_K = 22'd2250000;
    localparam logic [11:0] DENOM_K = 12'd3927;

    cord_t       fin_d;
    logic [30:0] z_pos;
    logic [50:0] p_est_reg;
    logic [52:0] p_ref_reg;
    meta_t       f_meta_reg;
    logic        f_nz_reg, f_dz_reg, f_v_reg;

    assign fin_d = cd_d[CORDIC_STEPS];
    assign z_pos = fin_d.z[31] ? 31'd0 : fin_d.z[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= cd_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_est_reg  <= 51'(z_pos) * 51'(RECIP);
            p_ref_reg  <= 53'(z_pos) * 53'(NUMER_K);
            f_meta_reg <= fin_d.meta;
            f_nz_reg   <= fin_d.num_zero;
            f_dz_reg   <= fin_d.den_zero;
        end
    end

    logic [10:0]        t_est;
    logic [23:0]        t_back;
    logic [53:0]        t_back_sh;
    logic [11:0]        t_fix;
    logic [11:0]        t_cap;
    logic signed [11:0] angle;
    logic signed [11:0] result_next;
    logic signed [11:0] result_reg;

    always_comb
    begin
        t_est     = p_est_reg[50:40];
        t_back    = 24'({1'b0, t_est} + 12'd1) * 24'(DENOM_K);
        t_back_sh = {t_back, 30'd0};
        t_fix     = {1'b0, t_est} + ((t_back_sh <= {1'b0, p_ref_reg}) ? 12'd1 : 12'd0);
        t_cap     = (t_fix > 12'd899) ? 12'd899 : t_fix;
        if (f_nz_reg)
        begin
            t_cap = 12'd0;
        end
        else if (f_dz_reg)
        begin
            t_cap = 12'd899;
        end
        angle       = f_meta_reg.neg ? (12'sd0 - $signed(t_cap)) : $signed(t_cap);
        result_next = (f_meta_reg.func == FUNC_SCALE_X) ? f_meta_reg.scale : angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;

endmodule

// ===== hw/rtl/tilt_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tilt_sqrt_cell
// One bit of a restoring integer square root: takes two radicand bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_sqrt_cell
    import tilt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_v,
    input  sq_t  in_d,
    output logic out_v,
    output sq_t  out_d
);

    logic        v_reg;
    sq_t         d_reg;
    sq_t         d_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    always_comb
    begin
        rem_sh = {in_d.rem[32:0], in_d.src[31:30]};
        trial  = {1'b0, in_d.root, 2'b01};
        ge     = (rem_sh >= trial);
        d_next       = in_d;
        d_next.src   = {in_d.src[29:0], 2'b00};
        d_next.rem   = ge ? (rem_sh - trial) : rem_sh;
        d_next.root  = {in_d.root[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

// ===== hw/rtl/tilt_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tilt_cordic_cell
// One vectoring CORDIC rotation with a fixed shift and angle step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_cordic_cell
    import tilt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_v,
    input  cord_t in_d,
    output logic  out_v,
    output cord_t out_d
);

    logic               v_reg;
    cord_t              d_reg;
    cord_t              d_next;
    logic signed [35:0] sx;
    logic signed [35:0] sy;

    always_comb
    begin
        sx     = in_d.x >>> IDX;
        sy     = in_d.y >>> IDX;
        d_next = in_d;
        if (!in_d.y[35])
        begin
            d_next.x = in_d.x + sy;
            d_next.y = in_d.y - sx;
            d_next.z = in_d.z + ATAN_Q30[IDX];
        end
        else
        begin
            d_next.x = in_d.x - sy;
            d_next.y = in_d.y + sx;
            d_next.z = in_d.z - ATAN_Q30[IDX];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

// ===== test/accel_tilt_angle_core_tb.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angle_core_tb
// Drives random and corner accelerometer samples through the tilt core with
// bursty input and stalling output, and checks every result against an
// in-bench predictor, a CORDIC model for the angle functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class tilt_scoreboard;
    logic signed [11:0] expected_q[$];

    static function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    static function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    static function automatic longint magnitude_root(longint a, longint b);
        longint unsigned s;
        s = a * a + b * b;
        return int_sqrt(s << 32);
    endfunction

    static function automatic longint angle_tenths(longint n, longint d);
        longint x, y, z, nx, t;
        if (n == 0) return 0;
        if (d == 0) return 899;
        x = d;
        y = n;
        z = 0;
        for (int i = 0; i < 20; i++)
        begin
            if (y >= 0)
            begin
                nx = x + shift_floor(y, i);
                y = y - shift_floor(x, i);
                z += tilt_pkg::ATAN_Q30[i];
            end
            else
            begin
                nx = x - shift_floor(y, i);
                y = y + shift_floor(x, i);
                z -= tilt_pkg::ATAN_Q30[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        t = (z * 18000000) / (64'sd31416 << 30);
        if (t > 899) t = 899;
        return t;
    endfunction

    function void note_sample(logic [1:0] f, logic signed [15:0] ax,
                              logic signed [15:0] ay, logic signed [15:0] az);
        longint x, y, z, t, r;
        x = ax;
        y = ay;
        z = az;
        case (f)
            tilt_pkg::FUNC_SCALE_X: r = (x * 980) / 16384;
            tilt_pkg::FUNC_TILT_Z:
            begin
                t = angle_tenths(magnitude_root(x, y), (z < 0 ? -z : z) << 16);
                r = (z < 0) ? -t : t;
            end
            tilt_pkg::FUNC_ANGLE_X:
            begin
                t = angle_tenths((x < 0 ? -x : x) << 16, magnitude_root(y, z));
                r = (x < 0) ? -t : t;
            end
            default:
            begin
                t = angle_tenths((y < 0 ? -y : y) << 16, magnitude_root(x, z));
                r = (y < 0) ? -t : t;
            end
        endcase
        expected_q.push_back(r[11:0]);
    endfunction

    // Empty string when the word matches.
    function string check_result(logic signed [11:0] got);
        logic signed [11:0] want;
        if (expected_q.size() == 0)
            return $sformatf("unexpected result %0d", got);
        want = expected_q.pop_front();
        if (got !== want)
            return $sformatf("result_value got %0d want %0d", got, want);
        return "";
    endfunction
endclass

module accel_tilt_angle_core_tb;
    import tilt_pkg::*;

    localparam int LATENCY = 55;
    localparam int NUM_RANDOM = 1310;
    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [11:0] result_value;

    tilt_scoreboard sb;
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;

    accel_tilt_angle_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    // Offer one word and hold it until it is taken.
    task automatic send_sample(logic [1:0] f, logic signed [15:0] x,
                               logic signed [15:0] y, logic signed [15:0] z);
        in_valid <= 1'b1;
        func <= f;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(f, x, y, z);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3: return 16'(int'($urandom_range(0, 33000)) - 16500);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: stall on its own pattern, with a long hold-off on request.
    initial
    begin
        int mode;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60))
            begin
                if (mode == 0)
                    out_stall <= 1'b0;
                else
                    out_stall <= ($urandom_range(0, 3) < mode);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            string msg;
            msg = sb.check_result(result_value);
            if (msg != "") report_mismatch(msg);
        end
    end

    // Watchdog: count cycles in which nothing moves.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("accel_tilt_angle_core_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic signed [15:0] corner[6];
        int burst;
        sb = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= FUNC_TILT_Z;
        accel_x <= '0;
        accel_y <= '0;
        accel_z <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        corner = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
        // zero numerator, zero denominator, negative z, extremes
        send_sample(FUNC_TILT_Z, 16'sd0, 16'sd0, 16'sd0);
        send_sample(FUNC_TILT_Z, 16'sd0, 16'sd0, -16'sd500);
        send_sample(FUNC_TILT_Z, 16'sd100, -16'sd200, 16'sd0);
        send_sample(FUNC_TILT_Z, 16'sd300, 16'sd400, -16'sd1000);
        send_sample(FUNC_ANGLE_X, 16'sd0, 16'sd0, 16'sd0);
        send_sample(FUNC_ANGLE_X, -16'sd5, 16'sd0, 16'sd0);
        send_sample(FUNC_ANGLE_X, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_sample(FUNC_ANGLE_Y, 16'sd0, 16'sd0, 16'sd0);
        send_sample(FUNC_ANGLE_Y, 16'sd0, 16'sh8000, 16'sd0);
        send_sample(FUNC_ANGLE_Y, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        for (int i = 0; i < 6; i++)
            send_sample(FUNC_SCALE_X, corner[i], corner[5 - i], corner[i]);
        for (int i = 0; i < 6; i++)
            send_sample(2'(i % 3), corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6]);

        // Fill the pipe against a blocked receiver.
        hold_off = 1'b1;
        for (int i = 0; i < 120; i++)
            send_sample(2'($urandom_range(0, 3)), random_axis(), random_axis(), random_axis());

        for (int n = 0; n < NUM_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++)
                send_sample(2'($urandom_range(0, 3)), random_axis(), random_axis(),
                            random_axis());
            idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0)
            $display("accel_tilt_angle_core_tb OK");
        else
            $display("accel_tilt_angle_core_tb NOT OK");
        $finish;
    end
endmodule
